@@ design/ipm_pkg.sv @@
package ipm_pkg;

    localparam int MAX_SIDE_DEF = 4096;
    localparam int CFG_W = 13;
    localparam int SUM_W = 42;
    localparam int MSE_W = 32;
    localparam int PSNR_W = 16;
    localparam int DIV_W = 44;
    localparam int LOG_FRAC = 28;
    localparam int LOG_W = 34;
    localparam logic [15:0] PEAK_SQ = 16'd65025;
    localparam logic [25:0] PSNR_K = 26'd50504453;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [0:0] REG_WIDTH = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_LOGN_NORM,
        ST_LOGN_ITER,
        ST_LOGS_NORM,
        ST_LOGS_ITER,
        ST_MUL,
        ST_ROUND,
        ST_OUT
    } back_state_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
    } frame_req_t;

endpackage

@@ design/ipm_front.sv @@
module ipm_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [47:0]                   pixels,
    input  logic                          last,
    output logic                          req_valid,
    input  logic                          req_ready,
    output ipm_pkg::frame_req_t           req
);

    localparam logic [ipm_pkg::SUM_W-1:0] SUM_MAX = '1;

    logic [ipm_pkg::SUM_W-1:0] sum_reg;
    logic [ipm_pkg::SUM_W-1:0] sum_next;
    logic [ipm_pkg::SUM_W-1:0] total;
    logic [17:0]               add;
    logic [ipm_pkg::SUM_W:0]   wide;
    logic [8:0]                d0;
    logic [8:0]                d1;
    logic [8:0]                d2;
    logic [7:0]                a0;
    logic [7:0]                a1;
    logic [7:0]                a2;
    logic [15:0]               s0;
    logic [15:0]               s1;
    logic [15:0]               s2;
    logic                      accept;

    always_comb
    begin
        d0 = {1'b0, pixels[7:0]} - {1'b0, pixels[31:24]};
        d1 = {1'b0, pixels[15:8]} - {1'b0, pixels[39:32]};
        d2 = {1'b0, pixels[23:16]} - {1'b0, pixels[47:40]};
        a0 = d0[8] ? 8'(-d0) : d0[7:0];
        a1 = d1[8] ? 8'(-d1) : d1[7:0];
        a2 = d2[8] ? 8'(-d2) : d2[7:0];
        s0 = a0 * a0;
        s1 = a1 * a1;
        s2 = a2 * a2;
        add = {2'b00, s0} + {2'b00, s1} + {2'b00, s2};
        wide = {1'b0, sum_reg} + {{(ipm_pkg::SUM_W-17){1'b0}}, add};
        total = wide[ipm_pkg::SUM_W] ? SUM_MAX : wide[ipm_pkg::SUM_W-1:0];
    end

    // last pixel needs room in the queue
    assign in_ready = !last || req_ready;
    assign accept = in_valid && in_ready;
    assign req_valid = accept && last;
    assign req.sum = total;

    always_comb
    begin
        sum_next = sum_reg;
        if (accept)
        begin
            sum_next = last ? '0 : total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

@@ design/ipm_queue.sv @@
module ipm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  ipm_pkg::frame_req_t wr_data,
    output logic                rd_valid,
    input  logic                rd_ready,
    output ipm_pkg::frame_req_t rd_data
);

    localparam int DEPTH = ipm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);

    ipm_pkg::frame_req_t      mem_reg [DEPTH];
    logic [PTR_W-1:0]         wp_reg;
    logic [PTR_W-1:0]         rp_reg;
    logic [PTR_W:0]           cnt_reg;
    logic                     do_wr;
    logic                     do_rd;

    assign wr_ready = cnt_reg != (PTR_W+1)'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data = mem_reg[rp_reg];
    assign do_wr = wr_valid && wr_ready;
    assign do_rd = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= (wp_reg == PTR_W'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (do_rd)
            begin
                rp_reg <= (rp_reg == PTR_W'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PTR_W+1)'(do_wr) - (PTR_W+1)'(do_rd);
        end
    end

endmodule

@@ design/ipm_back.sv @@
module ipm_back #(
    parameter int MAX_SIDE = ipm_pkg::MAX_SIDE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ipm_pkg::CFG_W-1:0]     width,
    input  logic [ipm_pkg::CFG_W-1:0]     height,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  ipm_pkg::frame_req_t           req,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ipm_pkg::PSNR_W-1:0]    psnr_db,
    output logic [ipm_pkg::MSE_W-1:0]     mse,
    output logic                          identical
);

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int D_W = 2 + 2 * SIDE_W;
    localparam int N_W = D_W + 16;
    localparam int X_W = (N_W > ipm_pkg::SUM_W) ? N_W : ipm_pkg::SUM_W;
    localparam int E_W = $clog2(X_W);
    localparam int NUM_W = ipm_pkg::SUM_W + 17;
    localparam int CNT_W = 6;
    localparam logic [63:0] MSE_CAP = 64'd65025 << 16;

    ipm_pkg::back_state_t st_reg, st_next;
    logic [ipm_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [D_W-1:0]            d_reg, d_next;
    logic [NUM_W-1:0]          rem_reg, rem_next;
    logic [NUM_W-1:0]          quo_reg, quo_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [X_W-1:0]            x_reg, x_next;
    logic [E_W-1:0]            e_reg, e_next;
    logic [32:0]               m_reg, m_next;
    logic [ipm_pkg::LOG_W-1:0] ln_reg, ln_next;
    logic [ipm_pkg::LOG_W-1:0] lg_reg, lg_next;
    logic [60:0]               prod_reg, prod_next;
    logic [ipm_pkg::PSNR_W-1:0] psnr_reg, psnr_next;
    logic [ipm_pkg::MSE_W-1:0] mse_reg, mse_next;
    logic                      same_reg, same_next;

    logic [SIDE_W-1:0]         we;
    logic [SIDE_W-1:0]         he;
    logic [NUM_W:0]            trial;
    logic [65:0]               sq;
    logic [32:0]               sqs;
    logic [E_W-1:0]            top;
    logic [ipm_pkg::LOG_W-1:0] dlog;
    logic [61:0]               rnd;

    function automatic logic [SIDE_W-1:0] side_eff(input logic [ipm_pkg::CFG_W-1:0] s);
        logic [SIDE_W-1:0] r;
        if (s == '0)
            r = SIDE_W'(1);
        else if ({{(32-ipm_pkg::CFG_W){1'b0}}, s} > 32'(MAX_SIDE))
            r = SIDE_W'(MAX_SIDE);
        else
            r = SIDE_W'(s);
        return r;
    endfunction

    always_comb
    begin
        top = '0;
        for (int i = 0; i < X_W; i++)
        begin
            if (x_reg[i])
            begin
                top = E_W'(i);
            end
        end
    end

    assign we = side_eff(width);
    assign he = side_eff(height);
    assign trial = {rem_reg, quo_reg[NUM_W-1]} - {{(NUM_W-D_W+1){1'b0}}, d_reg};
    assign sq = 66'(m_reg[31:0]) * 66'(m_reg[31:0]);
    assign sqs = sq[63:31];
    assign dlog = ln_reg - lg_reg;
    assign rnd = {1'b0, prod_reg} + (62'd1 << 43);

    assign req_ready = st_reg == ipm_pkg::ST_IDLE;
    assign out_valid = st_reg == ipm_pkg::ST_OUT;
    assign psnr_db = psnr_reg;
    assign mse = mse_reg;
    assign identical = same_reg;

    always_comb
    begin
        st_next = st_reg;
        sum_next = sum_reg;
        d_next = d_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        x_next = x_reg;
        e_next = e_reg;
        m_next = m_reg;
        ln_next = ln_reg;
        lg_next = lg_reg;
        prod_next = prod_reg;
        psnr_next = psnr_reg;
        mse_next = mse_reg;
        same_next = same_reg;
        case (st_reg)
            ipm_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    sum_next = req.sum;
                    d_next = D_W'(3) * D_W'(we) * D_W'(he);
                    st_next = ipm_pkg::ST_PREP;
                end
            end
            ipm_pkg::ST_PREP:
            begin
                same_next = sum_reg == '0;
                if (sum_reg == '0)
                begin
                    mse_next = '0;
                    psnr_next = '1;
                    st_next = ipm_pkg::ST_OUT;
                end
                else
                begin
                    // numerator = sum*65536 + d/2, long division
                    quo_next = {1'b0, sum_reg, 16'd0} + NUM_W'(d_reg >> 1);
                    rem_next = '0;
                    cnt_next = CNT_W'(NUM_W);
                    st_next = ipm_pkg::ST_DIV;
                end
            end
            ipm_pkg::ST_DIV:
            begin
                if (!trial[NUM_W])
                begin
                    rem_next = trial[NUM_W-1:0];
                    quo_next = {quo_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[NUM_W-2:0], quo_reg[NUM_W-1]};
                    quo_next = {quo_reg[NUM_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    x_next = X_W'(ipm_pkg::PEAK_SQ) * X_W'(d_reg);
                    st_next = ipm_pkg::ST_LOGN_NORM;
                end
            end
            ipm_pkg::ST_LOGN_NORM,
            ipm_pkg::ST_LOGS_NORM:
            begin
                if (st_reg == ipm_pkg::ST_LOGN_NORM)
                begin
                    mse_next = ({{(64-NUM_W){1'b0}}, quo_reg} > MSE_CAP) ? MSE_CAP[31:0]
                                                                         : quo_reg[31:0];
                end
                e_next = top;
                if (top >= E_W'(31))
                    m_next = 33'(x_reg >> (top - E_W'(31)));
                else
                    m_next = 33'(x_reg << (E_W'(31) - top));
                cnt_next = CNT_W'(ipm_pkg::LOG_FRAC);
                if (st_reg == ipm_pkg::ST_LOGN_NORM)
                begin
                    ln_next = '0;
                    st_next = ipm_pkg::ST_LOGN_ITER;
                end
                else
                begin
                    lg_next = '0;
                    st_next = ipm_pkg::ST_LOGS_ITER;
                end
            end
            ipm_pkg::ST_LOGN_ITER,
            ipm_pkg::ST_LOGS_ITER:
            begin
                if (sqs[32])
                    m_next = {1'b0, sqs[32:1]};
                else
                    m_next = sqs;
                cnt_next = cnt_reg - 1'b1;
                if (st_reg == ipm_pkg::ST_LOGN_ITER)
                begin
                    ln_next = {ln_reg[ipm_pkg::LOG_W-2:0], sqs[32]};
                    if (cnt_reg == CNT_W'(1))
                    begin
                        ln_next = {e_reg[5:0], ln_reg[26:0], sqs[32]};
                        x_next = X_W'(sum_reg);
                        st_next = ipm_pkg::ST_LOGS_NORM;
                    end
                end
                else
                begin
                    lg_next = {lg_reg[ipm_pkg::LOG_W-2:0], sqs[32]};
                    if (cnt_reg == CNT_W'(1))
                    begin
                        lg_next = {e_reg[5:0], lg_reg[26:0], sqs[32]};
                        st_next = ipm_pkg::ST_MUL;
                    end
                end
            end
            ipm_pkg::ST_MUL:
            begin
                prod_next = 61'(dlog) * 61'(ipm_pkg::PSNR_K);
                st_next = ipm_pkg::ST_ROUND;
                if (lg_reg >= ln_reg)
                begin
                    prod_next = '0;
                end
            end
            ipm_pkg::ST_ROUND:
            begin
                if (lg_reg >= ln_reg)
                    psnr_next = '0;
                else if (rnd[61:44] > 18'hFFFF)
                    psnr_next = '1;
                else
                    psnr_next = rnd[59:44];
                st_next = ipm_pkg::ST_OUT;
            end
            ipm_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    st_next = ipm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                st_next = ipm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ipm_pkg::ST_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        d_reg <= d_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        x_reg <= x_next;
        e_reg <= e_next;
        m_reg <= m_next;
        ln_reg <= ln_next;
        lg_reg <= lg_next;
        prod_reg <= prod_next;
        psnr_reg <= psnr_next;
        mse_reg <= mse_next;
        same_reg <= same_next;
    end

endmodule

@@ design/image_psnr_meter_top.sv @@
// image psnr meter
// s_axis carries one pixel pair per request: reference and test rgb bytes,
// tlast marks the final pixel of a frame
// m_axis carries one result per frame: psnr in q8.8 db, mse in q16.16 and
// the identical flag in tuser
// frame width and height are written through the cfg port, by the user only while idle; the block does not enforce it
// throughput: one pixel per cycle while s_axis_tready is high; the squared
// differences are summed as the pixels arrive
// once the back end is free, the result of a frame comes from a 59-step long
// division and two 28-step squaring logarithms taken in turn by one log unit;
// an identical frame skips them; the back end works on one
// frame at a time
// a two-entry queue holds finished frame sums, so a stalled receiver holds
// the last pixel of a frame only once the queue is full; other pixels flow
// reset clears the accumulator and the queue and sets both sides to 1
module image_psnr_meter_top #(
    parameter int MAX_SIDE = ipm_pkg::MAX_SIDE_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [ipm_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // ref_red, ref_green, ref_blue, test_red, test_green, test_blue
    input  logic [47:0]                s_axis_tdata,
    input  logic                       s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // psnr_db, mean_sq_error
    output logic [47:0]                m_axis_tdata,
    // identical
    output logic                       m_axis_tuser
);

    logic [ipm_pkg::CFG_W-1:0] width_reg;
    logic [ipm_pkg::CFG_W-1:0] height_reg;
    logic                      fq_valid;
    logic                      fq_ready;
    ipm_pkg::frame_req_t       fq_data;
    logic                      qb_valid;
    logic                      qb_ready;
    ipm_pkg::frame_req_t       qb_data;
    logic [15:0]               psnr;
    logic [31:0]               mse;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= ipm_pkg::CFG_W'(1);
            height_reg <= ipm_pkg::CFG_W'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_index == ipm_pkg::REG_WIDTH)
                width_reg <= cfg_data;
            else
                height_reg <= cfg_data;
        end
    end

    ipm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .pixels    (s_axis_tdata),
        .last      (s_axis_tlast),
        .req_valid (fq_valid),
        .req_ready (fq_ready),
        .req       (fq_data)
    );

    ipm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    ipm_back #(
        .MAX_SIDE (MAX_SIDE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .width     (width_reg),
        .height    (height_reg),
        .req_valid (qb_valid),
        .req_ready (qb_ready),
        .req       (qb_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .psnr_db   (psnr),
        .mse       (mse),
        .identical (m_axis_tuser)
    );

    assign m_axis_tdata = {mse, psnr};

endmodule
